// File: src/crc_checked_frame_receiver_defines.svh
// Assertion macros for the CRC-checked frame receiver.
// Depends on nothing; the asserting modules must have clk and arst_n in scope.
`ifndef CRC_CHECKED_FRAME_RECEIVER_DEFINES_SVH
`define CRC_CHECKED_FRAME_RECEIVER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check on every clock edge outside reset.
`define CFR_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check on every clock edge, reset included.
`define CFR_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CFR_ASSERT(name, prop, msg)
`define CFR_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// File: src/crc_cfr_pkg.sv
// Shared types, constants and the CRC-16 byte update for the frame receiver.
// No dependencies.
package crc_cfr_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [8:0]  POS_HDR_LAST = 9'd4;  // last header byte position
	localparam logic [8:0]  POS_PAYLOAD0 = 9'd5;  // position of first payload byte
	localparam logic [8:0]  POS_MAX = 9'd261;     // second CRC byte at full length

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_CRC_GOOD = 2'd1,
		KIND_CRC_BAD = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [3:0] message_class;
		logic       is_response;
		logic [7:0] message_type;
		logic [7:0] message_id;
		logic [7:0] payload_length;
	} result_t;

	// One byte of CRC-16, polynomial 0x1021, MSB first.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// File: src/crc_cfr_parser.sv
// Frame parser: header capture, payload pass-through and CRC check.
// Depends on crc_cfr_pkg and crc_checked_frame_receiver_defines.svh.
`include "crc_checked_frame_receiver_defines.svh"

module crc_cfr_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  crc_cfr_pkg::item_t  item,
	output logic                emit,
	output crc_cfr_pkg::result_t res
);

	logic        in_frame_q;
	logic [8:0]  pos_q;
	logic [15:0] crc_q;
	logic [3:0]  class_q;
	logic        resp_q;
	logic [7:0]  type_q;
	logic [7:0]  id_q;
	logic [7:0]  len_q;
	logic [7:0]  crc_hi_q;

	logic [8:0]  payload_last;
	logic [8:0]  crc_hi_pos;
	logic [8:0]  pos_next;
	logic [8:0]  index_full;
	logic [15:0] crc_next;
	logic        is_hdr;
	logic        is_payload;
	logic        is_crc_hi;
	logic        is_end;

	assign payload_last = crc_cfr_pkg::POS_HDR_LAST + {1'b0, len_q};
	assign crc_hi_pos   = payload_last + 9'd1;
	assign pos_next     = pos_q + 9'd1;
	assign index_full   = pos_q - crc_cfr_pkg::POS_PAYLOAD0;
	assign crc_next     = crc_cfr_pkg::crc16_byte(crc_q, item.rx_byte);

	always_comb begin
		is_hdr = 1'b0;
		is_payload = 1'b0;
		is_crc_hi = 1'b0;
		is_end = 1'b0;
		if (!item.frame_start && in_frame_q) begin
			if (pos_q <= crc_cfr_pkg::POS_HDR_LAST) begin
				is_hdr = 1'b1;
			end else if (pos_q <= payload_last) begin
				is_payload = 1'b1;
			end else if (pos_q == crc_hi_pos) begin
				is_crc_hi = 1'b1;
			end else begin
				is_end = 1'b1;
			end
		end
	end

	always_comb begin
		emit = is_payload || is_end;
		res.kind = crc_cfr_pkg::KIND_PAYLOAD;
		res.payload_byte = 8'd0;
		res.payload_index = 8'd0;
		if (is_payload) begin
			res.payload_byte = item.rx_byte;
			res.payload_index = index_full[7:0];
		end else if (is_end) begin
			res.kind = ({crc_hi_q, item.rx_byte} == crc_q) ?
				crc_cfr_pkg::KIND_CRC_GOOD : crc_cfr_pkg::KIND_CRC_BAD;
		end
		res.message_class = class_q;
		res.is_response = resp_q;
		res.message_type = type_q;
		res.message_id = id_q;
		res.payload_length = len_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q <= 9'd0;
			crc_q <= crc_cfr_pkg::CRC_INIT;
			class_q <= 4'd0;
			resp_q <= 1'b0;
			type_q <= 8'd0;
			id_q <= 8'd0;
			len_q <= 8'd0;
			crc_hi_q <= 8'd0;
		end else if (step) begin
			if (item.frame_start) begin
				in_frame_q <= 1'b1;
				pos_q <= 9'd1;
				crc_q <= crc_cfr_pkg::CRC_INIT;
			end else if (is_hdr) begin
				crc_q <= crc_next;
				pos_q <= pos_next;
				case (pos_q[2:0])
					3'd1: begin
						class_q <= item.rx_byte[7:4];
						resp_q <= item.rx_byte[3];
					end
					3'd2: type_q <= item.rx_byte;
					3'd3: id_q <= item.rx_byte;
					default: len_q <= item.rx_byte;
				endcase
			end else if (is_payload) begin
				crc_q <= crc_next;
				pos_q <= pos_next;
			end else if (is_crc_hi) begin
				crc_hi_q <= item.rx_byte;
				pos_q <= pos_next;
			end else if (is_end) begin
				in_frame_q <= 1'b0;
				pos_q <= 9'd0;
			end
		end
	end

	`CFR_ASSERT(a_idle_pos_zero, !in_frame_q |-> pos_q == 9'd0, "position set outside a frame")
	`CFR_ASSERT(a_pos_bound, pos_q <= crc_cfr_pkg::POS_MAX, "position beyond the longest frame")

endmodule

// File: src/crc_checked_frame_receiver.sv
// Path: each byte is registered in the input register; the parser result it gives
// is registered in the result register, from which it transfers on result.
// Throughput: one byte per cycle; the input register feeds the parser and the
// result register in a single pass, so only a stalled result can hold input.
// Bytes that give no result pass even while a result waits on the output.
// Reset (arst_n low, asynchronous) empties both registers and closes any frame.
`include "crc_checked_frame_receiver_defines.svh"

module crc_checked_frame_receiver (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  crc_cfr_pkg::item_t   item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output crc_cfr_pkg::result_t result
);

	// Input register: holds one transferred byte until the parser takes it.
	logic                 valid_s1;
	crc_cfr_pkg::item_t   item_s1;

	// Parser outputs for the byte in the input register.
	logic                 emit;
	crc_cfr_pkg::result_t res;

	// Advance the input register when it holds a byte and that byte either
	// gives no result or the result register is free or draining this cycle.
	logic                 adv;

	assign adv = valid_s1 && (!emit || !result_valid || !result_stall);

	// Stall the input side only while the held byte cannot advance.
	assign item_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	// Payload needs no reset; load on every transfer.
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	crc_cfr_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.emit   (emit),
		.res    (res)
	);

	// Result register: load a new result, drop a taken one, hold a stalled one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv && emit) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			result <= res;
		end
	end

	`CFR_ASSERT(a_stall_needs_held, item_stall |-> valid_s1 && emit && result_valid,
		"input stalled without a blocked result")
	`CFR_ASSERT(a_emit_lands, adv && emit |=> result_valid, "parser result not registered")
	`CFR_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !valid_s1 && !result_valid,
		"registers not empty after reset")

endmodule
